>>> src/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared sizes, command codes and controller/datapath interface types for
// the prefix tree dictionary.
// ----------------------------------------------------------------------------
package ptd_pkg;

   localparam int MAX_NODES     = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_W        = $clog2(MAX_NODES);
   localparam int COUNT_W       = NODE_W + 1;
   localparam int LETTER_W      = 5;
   localparam int CMD_W         = 2;
   localparam int CHILD_DEPTH   = MAX_NODES * ALPHABET_SIZE;
   localparam int SLOT_W        = $clog2(CHILD_DEPTH);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESOLVE,
      ST_FINISH,
      ST_SEARCH
   } ptd_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic resolve;
      logic mark_read;
      logic deliver;
   } ptd_ctrl_type;

   typedef struct packed {
      logic clear_last;
      logic lookup;
      logic req_last;
      logic item_last;
      logic need_mark_read;
      logic out_free;
   } ptd_status_type;

endpackage

>>> src/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer: clearing pass, letter lookup, child resolve, word end handling
// and result hand-off.
// ----------------------------------------------------------------------------
module ptd_ctrl
   import ptd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ptd_status_type status,
   output ptd_ctrl_type   ctrl
);

   ptd_state_type state_ff;
   ptd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.accept = 1'b1;
               if (status.lookup) begin
                  state_in = ST_RESOLVE;
               end else if (status.req_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RESOLVE: begin
            ctrl.resolve = 1'b1;
            state_in     = status.item_last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (status.need_mark_read) begin
               ctrl.mark_read = 1'b1;
               state_in       = ST_SEARCH;
            end else if (status.out_free) begin
               ctrl.deliver = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (status.out_free) begin
               ctrl.deliver = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

>>> src/ptd_datapath.sv
// ----------------------------------------------------------------------------
// ptd_datapath
// Child table and word end memories, walk registers, node allocator and the
// result register.
// ----------------------------------------------------------------------------
module ptd_datapath
   import ptd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ptd_ctrl_type        ctrl,
   output ptd_status_type      status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_has_letter,
   input  logic                req_last_letter,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic                rsp_pool_full
);

   logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
   logic              mark_mem  [MAX_NODES];

   logic [SLOT_W-1:0]  clear_cnt_ff,  clear_cnt_in;
   logic [NODE_W-1:0]  node_ff,       node_in;
   logic [COUNT_W-1:0] free_ff,       free_in;
   logic               missing_ff,    missing_in;
   logic               over_ff,       over_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic               last_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [NODE_W-1:0]  child_ff;
   logic               mark_ff;
   logic               found_ff;
   logic               full_ff;

   logic              walk_ok;
   logic              letter_ok;
   logic [SLOT_W-1:0] req_slot;
   logic              broken;
   logic              alloc;
   logic              mark_write;
   logic              found_val;

   assign walk_ok   = (req_cmd <= CMD_PREFIX) && req_has_letter && !missing_ff && !over_ff;
   assign letter_ok = req_letter < LETTER_W'(ALPHABET_SIZE);
   assign req_slot  = SLOT_W'(node_ff) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(req_letter);
   assign broken    = missing_ff || over_ff;
   assign alloc     = ctrl.resolve && (child_ff == '0) && (cmd_ff == CMD_INSERT)
                      && (free_ff != COUNT_W'(MAX_NODES));
   assign mark_write = ctrl.deliver && (cmd_ff == CMD_INSERT) && !broken;
   assign found_val = !broken && ((cmd_ff == CMD_INSERT) || (cmd_ff == CMD_PREFIX)
                      || ((cmd_ff == CMD_SEARCH) && mark_ff));

   assign status.clear_last     = clear_cnt_ff == SLOT_W'(CHILD_DEPTH - 1);
   assign status.lookup         = walk_ok && letter_ok;
   assign status.req_last       = req_last_letter;
   assign status.item_last      = last_ff;
   assign status.need_mark_read = (cmd_ff == CMD_SEARCH) && !broken;
   assign status.out_free       = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = found_ff;
   assign rsp_pool_full = full_ff;

   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      node_in      = node_ff;
      free_in      = free_ff;
      missing_in   = missing_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.clear_step) begin
         clear_cnt_in = clear_cnt_ff + SLOT_W'(1);
      end
      if (ctrl.accept && walk_ok && !letter_ok) begin
         missing_in = 1'b1;
      end
      if (ctrl.resolve) begin
         if (child_ff != '0) begin
            node_in = child_ff;
         end else if (cmd_ff != CMD_INSERT) begin
            missing_in = 1'b1;
         end else if (!alloc) begin
            over_in = 1'b1;
         end else begin
            node_in = free_ff[NODE_W-1:0];
            free_in = free_ff + COUNT_W'(1);
         end
      end
      if (ctrl.deliver) begin
         rsp_valid_in = 1'b1;
         node_in      = '0;
         missing_in   = 1'b0;
         over_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         node_ff      <= '0;
         free_ff      <= COUNT_W'(1);
         missing_ff   <= 1'b0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         node_ff      <= node_in;
         free_ff      <= free_in;
         missing_ff   <= missing_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff  <= req_cmd;
         last_ff <= req_last_letter;
         slot_ff <= req_slot;
      end
      if (ctrl.deliver) begin
         found_ff <= found_val;
         full_ff  <= over_ff && (cmd_ff <= CMD_PREFIX);
      end
   end

   // child table: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.clear_step) begin
         child_mem[clear_cnt_ff] <= '0;
      end else if (alloc) begin
         child_mem[slot_ff] <= free_ff[NODE_W-1:0];
      end
      if (ctrl.accept) begin
         child_ff <= child_mem[req_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear_step) begin
         mark_mem[clear_cnt_ff[NODE_W-1:0]] <= 1'b0;
      end else if (mark_write) begin
         mark_mem[node_ff] <= 1'b1;
      end
      if (ctrl.mark_read) begin
         mark_ff <= mark_mem[node_ff];
      end
   end

endmodule

>>> src/prefix_tree_dictionary.sv
// ----------------------------------------------------------------------------
// prefix_tree_dictionary
// 26-letter trie dictionary: insert, whole word search and prefix match,
// one letter per request transfer, one response on the final letter.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  cmd, letter, has_letter, last_letter
//  rsp      out        rsp_valid / rsp_stall  found, pool_full
//
//  Each letter takes a registered child-table read, then a resolve.
//  A final item then passes FINISH, and a search on an intact path also
//  reads the word end in SEARCH; a letterless item skips the lookup.
//  After reset a clearing pass over all 26624 child slots holds req_stall high.
//  The result register lets the walk continue while a response is stalled;
//  the next response waits only for that register.
// ----------------------------------------------------------------------------
module prefix_tree_dictionary
   import ptd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_has_letter,
   input  logic                req_last_letter,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic                rsp_pool_full
);

   ptd_ctrl_type   ctrl;
   ptd_status_type status;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   ptd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_letter      (req_letter),
      .req_has_letter  (req_has_letter),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_pool_full   (rsp_pool_full)
   );

`ifndef NO_ASSERTIONS
   a_deliver_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.deliver |-> status.out_free)
      else $error("response loaded while result register busy");

   a_deliver_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.deliver |=> rsp_valid)
      else $error("loaded response not presented");

   a_no_accept_in_resolve: assert property (@(posedge clock) disable iff (reset)
      ctrl.resolve |-> req_stall)
      else $error("request transfer during child resolve");

   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_step |-> !(ctrl.accept || ctrl.deliver || ctrl.resolve))
      else $error("walk activity during clearing pass");
`endif

endmodule

>>> bench/trie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_checker
// Watches the request and response channels of the prefix tree dictionary.
// Keeps its own node table, word end marks and walk state. Each accepted
// final request queues the predicted answer. Each accepted response is
// compared against the oldest queued answer.
// ----------------------------------------------------------------------------
module trie_checker
   import ptd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_has_letter,
   input  logic                req_last_letter,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_found,
   input  logic                rsp_pool_full,
   output int                  fail_count,
   output int                  answers_pending
);

   typedef struct packed {
      logic found;
      logic pool_full;
   } trie_answer_type;

   logic [NODE_W-1:0]  child_tbl [CHILD_DEPTH];
   logic               word_end  [MAX_NODES];
   logic [NODE_W-1:0]  walk_node;
   logic [COUNT_W-1:0] free_node;
   logic               walk_lost;
   logic               walk_overflow;
   trie_answer_type    answers_due [$];

   task automatic report_mismatch(input string msg);
      $display("trie_checker: %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic restart_walk();
      walk_node     = '0;
      walk_lost     = 1'b0;
      walk_overflow = 1'b0;
   endtask

   task automatic walk_letter(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l);
      int                slot;
      logic [NODE_W-1:0] nxt;
      if (walk_lost || walk_overflow)
         return;
      if (l >= ALPHABET_SIZE) begin
         walk_lost = 1'b1;
         return;
      end
      slot = int'(walk_node) * ALPHABET_SIZE + int'(l);
      nxt  = child_tbl[slot];
      if (nxt == '0) begin
         if (c != CMD_INSERT) begin
            walk_lost = 1'b1;
            return;
         end
         if (free_node >= MAX_NODES) begin
            walk_overflow = 1'b1;
            return;
         end
         nxt = free_node[NODE_W-1:0];
         free_node++;
         child_tbl[slot] = nxt;
      end
      walk_node = nxt;
   endtask

   task automatic take_item(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l,
                            input logic h, input logic f);
      trie_answer_type ans;
      if (c <= CMD_PREFIX && h)
         walk_letter(c, l);
      if (!f)
         return;
      ans = '0;
      if (c <= CMD_PREFIX) begin
         ans.pool_full = walk_overflow;
         if (!(walk_lost || walk_overflow)) begin
            case (c)
               CMD_INSERT: begin
                  word_end[walk_node] = 1'b1;
                  ans.found = 1'b1;
               end
               CMD_SEARCH: ans.found = word_end[walk_node];
               default:    ans.found = 1'b1;
            endcase
         end
      end
      answers_due.push_back(ans);
      restart_walk();
   endtask

   task automatic check_answer();
      trie_answer_type want;
      if (answers_due.size() == 0) begin
         report_mismatch("response transfer with no answer pending");
         return;
      end
      want = answers_due.pop_front();
      if (rsp_found !== want.found)
         report_mismatch($sformatf("found %b, predicted %b", rsp_found, want.found));
      if (rsp_pool_full !== want.pool_full)
         report_mismatch($sformatf("pool_full %b, predicted %b",
                                   rsp_pool_full, want.pool_full));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHILD_DEPTH; i++)
            child_tbl[i] = '0;
         for (int i = 0; i < MAX_NODES; i++)
            word_end[i] = 1'b0;
         free_node = COUNT_W'(1);
         restart_walk();
         answers_due.delete();
      end else begin
         if (req_valid && !req_stall)
            take_item(req_cmd, req_letter, req_has_letter, req_last_letter);
         if (rsp_valid && !rsp_stall)
            check_answer();
      end
      answers_pending <= answers_due.size();
   end

endmodule

>>> bench/tb_prefix_tree_dictionary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_tree_dictionary
// Drives words into the prefix tree dictionary: a directed set of corner
// cases, then random inserts, replays of stored words, probes and malformed
// sequences, with random idling on both channels. Checking is done by
// trie_checker; this module only stimulates and reports the verdict.
// ----------------------------------------------------------------------------
module tb_prefix_tree_dictionary;
   import ptd_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS  = 1900;
   localparam int IDLE_PCT     = 20;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_WORD     = 16;

   typedef struct packed {
      logic [4:0]                       len;
      logic [MAX_WORD-1:0][LETTER_W-1:0] ch;
   } word_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd         = CMD_INSERT;
   logic [LETTER_W-1:0] req_letter      = '0;
   logic                req_has_letter  = 1'b0;
   logic                req_last_letter = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic                rsp_found;
   logic                rsp_pool_full;

   int       mismatch_count;
   int       answers_pending;
   int       items_sent = 0;
   logic     quiet      = 1'b0;
   word_type lexicon [$];

   always #2 clock = ~clock;

   prefix_tree_dictionary dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_letter      (req_letter),
      .req_has_letter  (req_has_letter),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_pool_full   (rsp_pool_full)
   );

   trie_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_letter      (req_letter),
      .req_has_letter  (req_has_letter),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_pool_full   (rsp_pool_full),
      .fail_count      (mismatch_count),
      .answers_pending (answers_pending)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   task automatic send_item(input logic [CMD_W-1:0] c, input logic [LETTER_W-1:0] l,
                            input logic h, input logic f);
      quiet = (items_sent >= 900 && items_sent < 1200);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c;
      req_letter      <= l;
      req_has_letter  <= h;
      req_last_letter <= f;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_word(input logic [CMD_W-1:0] c, input word_type w);
      int i;
      for (i = 0; i < w.len; i++)
         send_item(c, w.ch[i], 1'b1, i == w.len - 1);
   endtask

   function automatic word_type random_word(input int lo, input int hi);
      word_type w;
      int       i;
      w     = '0;
      w.len = 5'($urandom_range(hi, lo));
      for (i = 0; i < w.len; i++)
         w.ch[i] = LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
      return w;
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(input bit with_unused);
      case ($urandom_range(with_unused ? 3 : 2))
         0:       return CMD_INSERT;
         1:       return CMD_SEARCH;
         2:       return CMD_PREFIX;
         default: return CMD_UNUSED;
      endcase
   endfunction

   // malformed words: stray commands, out of range letters, letterless items
   task automatic send_noise();
      int                  len;
      int                  i;
      logic [CMD_W-1:0]    base;
      logic [CMD_W-1:0]    c;
      logic [LETTER_W-1:0] l;
      logic                h;
      len  = $urandom_range(8, 1);
      base = pick_cmd(1);
      for (i = 0; i < len; i++) begin
         c = ($urandom_range(99) < 70) ? base : pick_cmd(1);
         if ($urandom_range(99) < 80)
            l = LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
         else
            l = LETTER_W'($urandom_range(31, ALPHABET_SIZE));
         h = ($urandom_range(99) < 85);
         send_item(c, l, h, i == len - 1);
      end
   endtask

   task automatic send_replay();
      word_type         w;
      logic [CMD_W-1:0] c;
      w = lexicon[$urandom_range(lexicon.size() - 1)];
      c = pick_cmd(0);
      if (c != CMD_INSERT && $urandom_range(1))
         w.len = 5'($urandom_range(w.len, 1));
      send_word(c, w);
   endtask

   initial begin
      word_type w;
      int       pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty words at the root
      send_item(CMD_SEARCH, 0, 1'b0, 1'b1);
      send_item(CMD_PREFIX, 31, 1'b0, 1'b1);
      send_item(CMD_INSERT, 0, 1'b0, 1'b1);
      send_item(CMD_SEARCH, 0, 1'b0, 1'b1);
      // lowest and highest letters
      send_item(CMD_INSERT, 0, 1'b1, 1'b0);
      send_item(CMD_INSERT, 25, 1'b1, 1'b1);
      send_item(CMD_SEARCH, 0, 1'b1, 1'b0);
      send_item(CMD_SEARCH, 25, 1'b1, 1'b1);
      send_item(CMD_SEARCH, 0, 1'b1, 1'b1);
      send_item(CMD_PREFIX, 0, 1'b1, 1'b1);
      send_item(CMD_PREFIX, 25, 1'b1, 1'b1);
      // letters past the alphabet
      send_item(CMD_INSERT, 26, 1'b1, 1'b1);
      send_item(CMD_SEARCH, 0, 1'b1, 1'b0);
      send_item(CMD_SEARCH, 31, 1'b1, 1'b1);
      // unused command
      send_item(CMD_UNUSED, 0, 1'b1, 1'b0);
      send_item(CMD_UNUSED, 25, 1'b1, 1'b1);
      // letterless item inside a word
      send_item(CMD_INSERT, 25, 1'b1, 1'b0);
      send_item(CMD_INSERT, 17, 1'b0, 1'b0);
      send_item(CMD_INSERT, 0, 1'b1, 1'b1);
      // mixed commands within one word
      send_item(CMD_INSERT, 0, 1'b1, 1'b0);
      send_item(CMD_SEARCH, 25, 1'b1, 1'b1);
      send_item(CMD_SEARCH, 25, 1'b1, 1'b0);
      send_item(CMD_UNUSED, 0, 1'b0, 1'b1);

      // long inserts drain the node pool partway through
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 48) begin
            w = random_word(4, 14);
            send_word(CMD_INSERT, w);
            lexicon.push_back(w);
         end else if (pick < 73 && lexicon.size() > 0) begin
            send_replay();
         end else if (pick < 81) begin
            w = random_word(1, 6);
            send_word($urandom_range(1) ? CMD_SEARCH : CMD_PREFIX, w);
         end else begin
            send_noise();
         end
      end
      req_valid <= 1'b0;

      // let the count of pending answers include the last transfer
      @(posedge clock);
      while (answers_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_prefix_tree_dictionary: done, clean");
      else
         $display("tb_prefix_tree_dictionary: done, errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_prefix_tree_dictionary: done, errors");
      $finish;
   end

endmodule
